/* rtl/int_stack_queue_assert.svh */
// ----------------------------------------------------------------------------
// int_stack_queue_assert.svh
// Assertion macros for the int_stack_queue RTL, used by isq_ctrl.
// ----------------------------------------------------------------------------
`ifndef INT_STACK_QUEUE_ASSERT_SVH
`define INT_STACK_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ISQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("int_stack_queue: assertion failed");
// expression must never be true outside reset
`define ISQ_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("int_stack_queue: forbidden condition seen");
`else
`define ISQ_ASSERT(lbl, clk, rst, prop)
`define ISQ_NEVER(lbl, clk, rst, expr)
`endif

`endif

/* rtl/isq_pkg.sv */
// ----------------------------------------------------------------------------
// isq_pkg
// Constants, codes and shared types of the int_stack_queue block.
// ----------------------------------------------------------------------------
package isq_pkg;

   localparam int CAPACITY = 1024;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int WORD_W   = 32;

   // minus MAXINT, returned wherever no word exists
   localparam logic signed [WORD_W-1:0] SENTINEL = 32'sh8000_0001;

   typedef enum logic [1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_GET   = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_UNDER = 2'd1,
      STAT_OVER  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] removed_word;
      status_type               status;
      logic [CNT_W-1:0]         fill_count;
      logic signed [WORD_W-1:0] top_word;
      logic signed [WORD_W-1:0] bottom_word;
   } result_type;

   typedef struct packed {
      logic                     we;
      logic [PTR_W-1:0]         waddr;
      logic signed [WORD_W-1:0] wdata;
      logic                     re;
      logic [PTR_W-1:0]         raddr_top;
      logic [PTR_W-1:0]         raddr_bot;
   } ram_req_type;

   // ring position off entries above base; both below CAPACITY
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (PTR_W+1)'(CAPACITY)) begin
         sum = sum - (PTR_W+1)'(CAPACITY);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

/* rtl/int_stack_queue.sv */
// ----------------------------------------------------------------------------
// int_stack_queue
// Bounded deque of signed 32-bit words: push and pop at the top, get at the
// bottom, clear. Valid/ready channels on both sides.
// ----------------------------------------------------------------------------
// Throughput is one transfer per cycle while results are taken. A request
// transfer lands in the input register; the single-pass step logic then
// loads the result register once that register is empty or its result is
// taken, and the result can transfer from there. A result that waits
// for rsp_ready holds the input register, and req_ready drops only while
// both registers are full and the result is not taken. The rate is set by
// the step logic, which uses cached top and bottom words and a two-read-port
// store that prefetches the neighbors of both ends for the next step. The
// store needs no clearing pass: the bottom pointer and fill count decide
// which entries are live. Capacity is 1024 words; a push to a full store
// is refused with status overflow, a pop or get on an empty store reports
// underflow, and missing words read as minus MAXINT.
module int_stack_queue
   import isq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_func,
   input  logic signed [WORD_W-1:0] req_push_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_removed_word,
   output logic [1:0]               rsp_status,
   output logic [CNT_W-1:0]         rsp_fill_count,
   output logic signed [WORD_W-1:0] rsp_top_word,
   output logic signed [WORD_W-1:0] rsp_bottom_word
);

   logic                     in_valid_ff, in_valid_in;
   logic [1:0]               in_func_ff;
   logic signed [WORD_W-1:0] in_word_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_data_ff;
   result_type               step_result;
   logic                     req_xfer;
   logic                     advance;

   // handshake
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign req_xfer    = req_valid && req_ready;
   assign in_valid_in = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_func_ff <= req_func;
         in_word_ff <= req_push_word;
      end
   end

   isq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (advance),
      .step_func   (func_type'(in_func_ff)),
      .step_word   (in_word_ff),
      .step_result (step_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_removed_word = rsp_data_ff.removed_word;
   assign rsp_status       = rsp_data_ff.status;
   assign rsp_fill_count   = rsp_data_ff.fill_count;
   assign rsp_top_word     = rsp_data_ff.top_word;
   assign rsp_bottom_word  = rsp_data_ff.bottom_word;

endmodule

/* rtl/isq_ram.sv */
// ----------------------------------------------------------------------------
// isq_ram
// Word store: one write port, two registered read ports, with write-to-read
// forwarding when a read hits the address written in the same cycle.
// ----------------------------------------------------------------------------
module isq_ram
   import isq_pkg::*;
(
   input  logic                     clock,
   input  ram_req_type              ram_req,
   output logic signed [WORD_W-1:0] rd_top,
   output logic signed [WORD_W-1:0] rd_bot
);

   logic signed [WORD_W-1:0] mem [CAPACITY];
   logic signed [WORD_W-1:0] rd_top_ff;
   logic signed [WORD_W-1:0] rd_bot_ff;
   logic signed [WORD_W-1:0] fwd_data_ff;
   logic                     fwd_top_ff;
   logic                     fwd_bot_ff;

   // memory array
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rd_top_ff <= mem[ram_req.raddr_top];
         rd_bot_ff <= mem[ram_req.raddr_bot];
      end
   end

   // same-cycle collision capture
   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         fwd_top_ff  <= ram_req.we && (ram_req.waddr == ram_req.raddr_top);
         fwd_bot_ff  <= ram_req.we && (ram_req.waddr == ram_req.raddr_bot);
         fwd_data_ff <= ram_req.wdata;
      end
   end

   assign rd_top = fwd_top_ff ? fwd_data_ff : rd_top_ff;
   assign rd_bot = fwd_bot_ff ? fwd_data_ff : rd_bot_ff;

endmodule

/* rtl/isq_ctrl.sv */
// ----------------------------------------------------------------------------
// isq_ctrl
// Step logic of the deque: pointer and count update, cached top and bottom
// words, and prefetch of the words next to them from the store.
// ----------------------------------------------------------------------------
`include "int_stack_queue_assert.svh"

module isq_ctrl
   import isq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_valid,
   input  func_type                 step_func,
   input  logic signed [WORD_W-1:0] step_word,
   output result_type               step_result
);

   logic [PTR_W-1:0]         bot_ptr_ff, bot_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [WORD_W-1:0] top_w_ff, top_w_in;
   logic signed [WORD_W-1:0] bot_w_ff, bot_w_in;
   logic signed [WORD_W-1:0] below_top;
   logic signed [WORD_W-1:0] above_bot;
   logic signed [WORD_W-1:0] removed;
   status_type               status;
   logic                     full;
   logic                     empty;
   logic                     push_ok;
   logic [PTR_W-1:0]         top_off;
   ram_req_type              ram_req;

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // next state of one step
   always_comb begin
      bot_ptr_in = bot_ptr_ff;
      count_in   = count_ff;
      top_w_in   = top_w_ff;
      bot_w_in   = bot_w_ff;
      removed    = SENTINEL;
      status     = STAT_OK;
      push_ok    = 1'b0;
      case (step_func)
         FUNC_PUSH: begin
            if (full) begin
               status = STAT_OVER;
            end else begin
               push_ok  = 1'b1;
               count_in = count_ff + CNT_W'(1);
               top_w_in = step_word;
               if (empty) begin
                  bot_w_in = step_word;
               end
            end
         end
         FUNC_POP: begin
            if (empty) begin
               status = STAT_UNDER;
            end else begin
               removed  = top_w_ff;
               count_in = count_ff - CNT_W'(1);
               top_w_in = below_top;
            end
         end
         FUNC_GET: begin
            if (empty) begin
               status = STAT_UNDER;
            end else begin
               removed    = bot_w_ff;
               count_in   = count_ff - CNT_W'(1);
               bot_ptr_in = ring_add(bot_ptr_ff, PTR_W'(1));
               bot_w_in   = above_bot;
            end
         end
         FUNC_CLEAR: begin
            bot_ptr_in = '0;
            count_in   = '0;
         end
         default: begin
         end
      endcase
   end

   // store access: write the pushed word, prefetch neighbors of next state
   assign top_off = (count_in >= CNT_W'(2)) ? PTR_W'(count_in - CNT_W'(2)) : '0;

   always_comb begin
      ram_req.we        = step_valid && push_ok;
      ram_req.waddr     = ring_add(bot_ptr_ff, count_ff[PTR_W-1:0]);
      ram_req.wdata     = step_word;
      ram_req.re        = step_valid;
      ram_req.raddr_top = ring_add(bot_ptr_in, top_off);
      ram_req.raddr_bot = ring_add(bot_ptr_in, PTR_W'(1));
   end

   isq_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_top  (below_top),
      .rd_bot  (above_bot)
   );

   // result of the step
   always_comb begin
      step_result.removed_word = removed;
      step_result.status       = status;
      step_result.fill_count   = count_in;
      step_result.top_word     = (count_in == '0) ? SENTINEL : top_w_in;
      step_result.bottom_word  = (count_in == '0) ? SENTINEL : bot_w_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bot_ptr_ff <= '0;
         count_ff   <= '0;
      end else if (step_valid) begin
         bot_ptr_ff <= bot_ptr_in;
         count_ff   <= count_in;
      end
   end

   // cached end words
   always_ff @(posedge clock) begin
      if (step_valid) begin
         top_w_ff <= top_w_in;
         bot_w_ff <= bot_w_in;
      end
   end

   `ISQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `ISQ_ASSERT(a_idle_hold, clock, reset, !step_valid |=> $stable(count_ff) && $stable(bot_ptr_ff))
   `ISQ_ASSERT(a_clear_empties, clock, reset, step_valid && step_func == FUNC_CLEAR |=> count_ff == '0 && bot_ptr_ff == '0)
   `ISQ_NEVER(a_over_only_full, clock, reset, step_valid && status == STAT_OVER && !full)

endmodule
